>>> rtl/environmental_sensor_compensation_top_macros.svh
// Assertion macros shared by the compensation RTL.
`ifndef ENVIRONMENTAL_SENSOR_COMPENSATION_TOP_MACROS_SVH
`define ENVIRONMENTAL_SENSOR_COMPENSATION_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ESC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define ESC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/escomp_pkg.sv
// Shared constants and helper functions for the sensor compensation block.
`default_nettype none
package escomp_pkg;

  localparam int DW = 64;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM     = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_PDIV0  = 2'd1;
  localparam logic [1:0] ST_NOTEMP = 2'd2;

  function automatic logic [DW-1:0] sx8(input logic [7:0] v);
    return {{(DW-8){v[7]}}, v};
  endfunction

  function automatic logic [DW-1:0] sx12(input logic [11:0] v);
    return {{(DW-12){v[11]}}, v};
  endfunction

  function automatic logic [DW-1:0] sx16(input logic [15:0] v);
    return {{(DW-16){v[15]}}, v};
  endfunction

  function automatic logic [DW-1:0] sx32(input logic [31:0] v);
    return {{(DW-32){v[31]}}, v};
  endfunction

  // Arithmetic right shift of a 64-bit word
  function automatic logic [DW-1:0] asr(input logic [DW-1:0] v, input logic [5:0] s);
    return $unsigned($signed(v) >>> s);
  endfunction

endpackage
`default_nettype wire

>>> rtl/environmental_sensor_compensation_top.sv
// Top level: sequencer driving a shared multiplier and divider for sensor compensation.
//
// Usage: write the five calibration registers on the cfg channel (index 0..4) while
// idle; cfg_ready is always high. Send one item on s_* (s_tuser = select mask,
// s_tdata = raw pressure, temperature, humidity). One result item leaves on m_*
// (m_tdata = temperature, pressure, humidity; m_tuser = status).
// Each multiply runs in the shared 32x32-based multiplier, the pressure division in the
// one-bit-per-cycle divider. s_tready is high only in the idle state, so a new item is
// taken only once the previous one has been handed to the output register.
// The finished result sits in an output register, so the next item is taken while
// the receiver stalls; a further result then waits until the register is free.
// Reset clears the calibration registers, the kept fine temperature and all
// control state; no item is pending after reset.
`default_nettype none
`include "environmental_sensor_compensation_top_macros.svh"
module environmental_sensor_compensation_top
  import escomp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [55:0]          s_tdata,   // raw_pressure[19:0], raw_temperature, raw_humidity
  input  wire logic [2:0]           s_tuser,   // select_mask
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [63:0]               m_tdata,   // temperature_centi, pressure_q24_8, humidity_q7_10
  output logic [1:0]                m_tuser,   // status
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DW-1:0]        cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE, S_T0, S_T1, S_T2, S_T3, S_T4,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
    S_P10, S_P11, S_P12, S_P13, S_P14,
    S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8, S_H9,
    S_OUT
  } state_t;

  state_t state;

  logic [47:0]   cal_t, cal_pa, cal_pb, cal_pc;
  logic [63:0]   cal_h;
  logic [31:0]   fine;
  logic [2:0]    mask;
  logic [19:0]   adc_p, adc_t;
  logic [15:0]   adc_h;
  logic [DW-1:0] ra, rb, rc;
  logic [14:0]   t_out;
  logic [31:0]   p_out;
  logic [16:0]   h_out;
  logic [1:0]    status;
  logic          unit_wait;

  logic [DW-1:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [DW-1:0] h1, h2, h3, h4, h5, h6;
  logic [DW-1:0] mul_a, mul_b, mul_p, div_q, num_mag, den_mag, hc;
  logic          is_mul, mul_go, mul_done, div_go, div_done;
  logic [DW-1:0] tt, pv, hv;

  // Unpack calibration fields
  always_comb begin
    t1 = {48'b0, cal_t[15:0]};
    t2 = sx16(cal_t[31:16]);
    t3 = sx16(cal_t[47:32]);
    p1 = {48'b0, cal_pa[15:0]};
    p2 = sx16(cal_pa[31:16]);
    p3 = sx16(cal_pa[47:32]);
    p4 = sx16(cal_pb[15:0]);
    p5 = sx16(cal_pb[31:16]);
    p6 = sx16(cal_pb[47:32]);
    p7 = sx16(cal_pc[15:0]);
    p8 = sx16(cal_pc[31:16]);
    p9 = sx16(cal_pc[47:32]);
    h1 = {56'b0, cal_h[7:0]};
    h2 = sx16(cal_h[23:8]);
    h3 = {56'b0, cal_h[31:24]};
    h4 = sx12(cal_h[43:32]);
    h5 = sx12(cal_h[55:44]);
    h6 = sx8(cal_h[63:56]);
  end

  // Route operands to the shared multiplier
  always_comb begin
    hc     = asr(rb, 6'd15);
    is_mul = 1'b1;
    mul_a  = ra;
    mul_b  = ra;
    case (state)
      S_T1:  begin mul_a = ra; mul_b = t2; end
      S_T2:  begin mul_a = rb; mul_b = rb; end
      S_T3:  begin mul_a = rb; mul_b = t3; end
      S_P1:  begin mul_a = ra; mul_b = ra; end
      S_P2:  begin mul_a = rb; mul_b = p6; end
      S_P3:  begin mul_a = ra; mul_b = p5; end
      S_P4:  begin mul_a = rb; mul_b = p3; end
      S_P5:  begin mul_a = ra; mul_b = p2; end
      S_P6:  begin mul_a = ra + (64'd1 << 47); mul_b = p1; end
      S_P8:  begin mul_a = rb; mul_b = 64'd3125; end
      S_P11: begin mul_a = p9; mul_b = rc; end
      S_P12: begin mul_a = ra; mul_b = rc; end
      S_P13: begin mul_a = p8; mul_b = rb; end
      S_H1:  begin mul_a = h5; mul_b = ra; end
      S_H2:  begin mul_a = ra; mul_b = h6; end
      S_H3:  begin mul_a = ra; mul_b = h3; end
      S_H4:  begin mul_a = rc; mul_b = ra; end
      S_H5:  begin mul_a = rc; mul_b = h2; end
      S_H6:  begin mul_a = rb; mul_b = rc; end
      S_H7:  begin mul_a = hc; mul_b = hc; end
      S_H8:  begin mul_a = ra; mul_b = h1; end
      default: is_mul = 1'b0;
    endcase
    mul_go  = is_mul && !unit_wait;
    div_go  = (state == S_P9) && !unit_wait;
    num_mag = rb[DW-1] ? (64'd0 - rb) : rb;
    den_mag = ra[DW-1] ? (64'd0 - ra) : ra;
    tt      = asr((rc << 2) + rc + 64'd128, 6'd8);
    pv      = asr(rb + rc, 6'd8) + (p7 << 4);
    hv      = ra;
  end

  escomp_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .p    (mul_p)
  );

  escomp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (num_mag),
    .den  (den_mag),
    .done (div_done),
    .quo  (div_q)
  );

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      unit_wait <= 1'b0;
      m_tvalid  <= 1'b0;
      fine      <= '0;
      cal_t     <= '0;
      cal_pa    <= '0;
      cal_pb    <= '0;
      cal_pc    <= '0;
      cal_h     <= '0;
    end else begin
      // Take configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TEMP:    cal_t  <= cfg_data[47:0];
          CFG_PRESS_A: cal_pa <= cfg_data[47:0];
          CFG_PRESS_B: cal_pb <= cfg_data[47:0];
          CFG_PRESS_C: cal_pc <= cfg_data[47:0];
          CFG_HUM:     cal_h  <= cfg_data;
          default: ;
        endcase
      end

      // Track the outstanding unit operation
      if (mul_go || div_go) begin
        unit_wait <= 1'b1;
      end else if (mul_done || div_done) begin
        unit_wait <= 1'b0;
      end

      // Drop the result once taken, unless a new one replaces it
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            mask   <= s_tuser;
            adc_p  <= s_tdata[19:0];
            adc_t  <= s_tdata[39:20];
            adc_h  <= s_tdata[55:40];
            t_out  <= '0;
            p_out  <= '0;
            h_out  <= '0;
            status <= ST_OK;
            if (s_tuser[1]) state <= S_T0;
            else if (s_tuser[0]) state <= S_P0;
            else if (s_tuser[2]) state <= S_H0;
            else state <= S_OUT;
          end
        end
        // Temperature
        S_T0: begin
          ra    <= {47'b0, adc_t[19:3]} - (t1 << 1);
          rb    <= {48'b0, adc_t[19:4]} - t1;
          state <= S_T1;
        end
        S_T1: if (mul_done) begin ra <= asr(mul_p, 6'd11); state <= S_T2; end
        S_T2: if (mul_done) begin rb <= asr(mul_p, 6'd12); state <= S_T3; end
        S_T3: if (mul_done) begin rc <= ra + asr(mul_p, 6'd14); state <= S_T4; end
        S_T4: begin
          fine <= rc[31:0];
          if ($signed(tt) < -64'sd4000) t_out <= -15'sd4000;
          else if ($signed(tt) > 64'sd8500) t_out <= 15'sd8500;
          else t_out <= tt[14:0];
          if (mask[0]) state <= S_P0;
          else if (mask[2]) state <= S_H0;
          else state <= S_OUT;
        end
        // Pressure
        S_P0: begin
          ra    <= sx32(fine) - 64'd128000;
          state <= S_P1;
        end
        S_P1: if (mul_done) begin rb <= mul_p; state <= S_P2; end
        S_P2: if (mul_done) begin rc <= mul_p; state <= S_P3; end
        S_P3: if (mul_done) begin
          rc    <= rc + (mul_p << 17) + (p4 << 35);
          state <= S_P4;
        end
        S_P4: if (mul_done) begin rb <= asr(mul_p, 6'd8); state <= S_P5; end
        S_P5: if (mul_done) begin ra <= rb + (mul_p << 12); state <= S_P6; end
        S_P6: if (mul_done) begin
          ra <= asr(mul_p, 6'd33);
          if (asr(mul_p, 6'd33) == '0) begin
            status <= ST_PDIV0;
            state  <= S_OUT;
          end else begin
            state <= S_P7;
          end
        end
        S_P7: begin
          rb    <= ((64'd1048576 - {44'b0, adc_p}) << 31) - rc;
          state <= S_P8;
        end
        S_P8: if (mul_done) begin rb <= mul_p; state <= S_P9; end
        S_P9: if (div_done) begin
          rb    <= (rb[DW-1] ^ ra[DW-1]) ? (64'd0 - div_q) : div_q;
          state <= S_P10;
        end
        S_P10: begin
          rc    <= asr(rb, 6'd13);
          state <= S_P11;
        end
        S_P11: if (mul_done) begin ra <= mul_p; state <= S_P12; end
        S_P12: if (mul_done) begin ra <= asr(mul_p, 6'd25); state <= S_P13; end
        S_P13: if (mul_done) begin rc <= asr(mul_p, 6'd19) + ra; state <= S_P14; end
        S_P14: begin
          p_out <= pv[31:0];
          state <= mask[2] ? S_H0 : S_OUT;
        end
        // Humidity
        S_H0: begin
          if (fine == '0) begin
            status <= ST_NOTEMP;
            state  <= S_OUT;
          end else begin
            ra    <= sx32(fine) - 64'd76800;
            state <= S_H1;
          end
        end
        S_H1: if (mul_done) begin
          rb    <= asr(({48'b0, adc_h} << 14) - (h4 << 20) - mul_p + 64'd16384, 6'd15);
          state <= S_H2;
        end
        S_H2: if (mul_done) begin rc <= asr(mul_p, 6'd10); state <= S_H3; end
        S_H3: if (mul_done) begin ra <= asr(mul_p, 6'd11) + 64'd32768; state <= S_H4; end
        S_H4: if (mul_done) begin rc <= asr(mul_p, 6'd10) + 64'd2097152; state <= S_H5; end
        S_H5: if (mul_done) begin rc <= asr(mul_p + 64'd8192, 6'd14); state <= S_H6; end
        S_H6: if (mul_done) begin rb <= mul_p; state <= S_H7; end
        S_H7: if (mul_done) begin ra <= asr(mul_p, 6'd7); state <= S_H8; end
        S_H8: if (mul_done) begin ra <= rb - asr(mul_p, 6'd4); state <= S_H9; end
        S_H9: begin
          if ($signed(hv) < 64'sd0) h_out <= '0;
          else if ($signed(hv) > 64'sd419430400) h_out <= 17'd102400;
          else h_out <= hv[28:12];
          state <= S_OUT;
        end
        // Hand the result to the output register when it is free
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {h_out, p_out, t_out};
            m_tuser  <= status;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // An accepted item keeps the input closed for the next cycle
  `ESC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // A zero pressure divisor leaves pressure and humidity at zero
  `ESC_ASSERT_IMP(a_pdiv0_zero, m_tvalid && m_tuser == ST_PDIV0, m_tdata[63:15] == '0)
  // Humidity without a temperature reads zero
  `ESC_ASSERT_IMP(a_notemp_zero, m_tvalid && m_tuser == ST_NOTEMP, m_tdata[63:47] == '0)
  // The multiplier and divider are never started together
  `ESC_ASSERT_IMP(a_one_unit, mul_go, !div_go && !unit_wait)

endmodule
`default_nettype wire

>>> rtl/escomp_mul.sv
// Shared 64x64 multiplier (low 64 bits) built from one 32x32 multiplier.
`default_nettype none
module escomp_mul
  import escomp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          go,
  input  wire logic [DW-1:0] a,
  input  wire logic [DW-1:0] b,
  output logic               done,
  output logic [DW-1:0]      p
);

  localparam int HW = DW / 2;

  logic [DW-1:0] a_r;
  logic [DW-1:0] b_r;
  logic [DW-1:0] prod;
  logic [DW-1:0] acc;
  logic [1:0]    cnt;
  logic          busy;
  logic [HW-1:0] ma;
  logic [HW-1:0] mb;

  // Pick the partial product for this cycle
  always_comb begin
    ma = (cnt == 2'd2) ? a_r[DW-1:HW] : a_r[HW-1:0];
    case (cnt)
      2'd0:    mb = b_r[HW-1:0];
      2'd1:    mb = b_r[DW-1:HW];
      default: mb = b_r[HW-1:0];
    endcase
  end

  // Multiply, then accumulate the registered product
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (go) begin
      a_r  <= a;
      b_r  <= b;
      cnt  <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      prod <= DW'(ma) * DW'(mb);
      cnt  <= cnt + 2'd1;
      done <= (cnt == 2'd3);
      case (cnt)
        2'd0: acc <= acc;
        2'd1: acc <= prod;
        2'd2: acc <= acc + {prod[HW-1:0], {HW{1'b0}}};
        default: begin
          acc  <= acc + {prod[HW-1:0], {HW{1'b0}}};
          busy <= 1'b0;
        end
      endcase
    end else begin
      done <= 1'b0;
    end
  end

  assign p = acc;

endmodule
`default_nettype wire

>>> rtl/escomp_div.sv
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
`default_nettype none
module escomp_div
  import escomp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          go,
  input  wire logic [DW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [DW-1:0]      quo
);

  logic [DW-1:0] rem;
  logic [DW-1:0] q;
  logic [DW-1:0] den_r;
  logic [5:0]    cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  always_comb begin
    trial = {rem, q[DW-1]};
    diff  = trial - {1'b0, den_r};
  end

  // Shift in one numerator bit and subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (go) begin
      rem   <= '0;
      q     <= num;
      den_r <= den;
      cnt   <= '0;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else if (busy) begin
      if (!diff[DW]) begin
        rem <= diff[DW-1:0];
        q   <= {q[DW-2:0], 1'b1};
      end else begin
        rem <= trial[DW-1:0];
        q   <= {q[DW-2:0], 1'b0};
      end
      cnt  <= cnt + 6'd1;
      done <= (cnt == 6'd63);
      if (cnt == 6'd63) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign quo = q;

endmodule
`default_nettype wire

>>> tb/sv/tb_environmental_sensor_compensation_top.sv
// Self-checking testbench for the sensor compensation top level.
`timescale 1ns / 100ps
`default_nettype none
module tb_environmental_sensor_compensation_top;
  import escomp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;

  typedef struct packed {
    logic [14:0] temp_centi;
    logic [31:0] press_q;
    logic [16:0] hum_q;
    logic [1:0]  status;
  } comp_result_t;

  // Compensation predictor with its own calibration copy and kept fine temperature
  class comp_scoreboard;
    logic [63:0]  cal[5];
    logic [31:0]  t_fine;
    comp_result_t pending[$];
    int           errors;

    function new();
      foreach (cal[i]) cal[i] = '0;
      t_fine = '0;
      errors = 0;
    endfunction

    function automatic logic [63:0] shr_s(logic [63:0] v, int s);
      return $signed(v) >>> s;
    endfunction

    function automatic logic [63:0] sext(logic [63:0] v, int w);
      logic [63:0] m, f;
      m = 64'd1 << (w - 1);
      f = v & ((64'd1 << w) - 64'd1);
      return (f ^ m) - m;
    endfunction

    // Signed quotient truncated toward zero, via magnitudes
    function automatic logic [63:0] quot_s(logic [63:0] a, logic [63:0] b);
      logic [63:0] ua, ub, q;
      ua = a[63] ? 64'd0 - a : a;
      ub = b[63] ? 64'd0 - b : b;
      q  = ua / ub;
      return (a[63] != b[63]) ? 64'd0 - q : q;
    endfunction

    function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        CFG_TEMP, CFG_PRESS_A, CFG_PRESS_B, CFG_PRESS_C: cal[idx] = data & 64'hFFFF_FFFF_FFFF;
        CFG_HUM: cal[idx] = data;
        default: ;
      endcase
    endfunction

    // Compute the expected result of one accepted item
    function void note_input(logic [2:0] mask, logic [19:0] raw_p, logic [19:0] raw_t,
                             logic [15:0] raw_h);
      comp_result_t r;
      logic [63:0] adc_p, adc_t, adc_h, t1, t2, t3, v1, v2, d, tf, p, q;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] h1, h2, h3, h4, h5, h6, a, b, c, v;
      logic        skip_h;
      r = '0;
      skip_h = 1'b0;
      adc_p = {44'd0, raw_p};
      adc_t = {44'd0, raw_t};
      adc_h = {48'd0, raw_h};
      // temperature first: it refreshes the fine term
      if (mask[1]) begin
        t1 = cal[CFG_TEMP] & 64'hFFFF;
        t2 = sext(cal[CFG_TEMP] >> 16, 16);
        t3 = sext(cal[CFG_TEMP] >> 32, 16);
        v1 = (adc_t >> 3) - (t1 << 1);
        d  = (adc_t >> 4) - t1;
        v1 = shr_s(v1 * t2, 11);
        v2 = shr_s(shr_s(d * d, 12) * t3, 14);
        tf = v1 + v2;
        t_fine = tf[31:0];
        v = shr_s(tf * 64'd5 + 64'd128, 8);
        if ($signed(v) < -64'sd4000) v = -64'sd4000;
        if ($signed(v) > 64'sd8500) v = 64'sd8500;
        r.temp_centi = v[14:0];
      end
      // pressure, may stop on a zero divisor
      if (mask[0]) begin
        tf = sext({32'd0, t_fine}, 32);
        p1 = cal[CFG_PRESS_A] & 64'hFFFF;
        p2 = sext(cal[CFG_PRESS_A] >> 16, 16);
        p3 = sext(cal[CFG_PRESS_A] >> 32, 16);
        p4 = sext(cal[CFG_PRESS_B], 16);
        p5 = sext(cal[CFG_PRESS_B] >> 16, 16);
        p6 = sext(cal[CFG_PRESS_B] >> 32, 16);
        p7 = sext(cal[CFG_PRESS_C], 16);
        p8 = sext(cal[CFG_PRESS_C] >> 16, 16);
        p9 = sext(cal[CFG_PRESS_C] >> 32, 16);
        v1 = tf - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = shr_s(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = shr_s(((64'd1 << 47) + v1) * p1, 33);
        if (v1 == 64'd0) begin
          r.status = ST_PDIV0;
          skip_h = 1'b1;
        end else begin
          p  = 64'd1048576 - adc_p;
          p  = quot_s(((p << 31) - v2) * 64'd3125, v1);
          q  = shr_s(p, 13);
          v1 = shr_s(p9 * q * q, 25);
          v2 = shr_s(p8 * p, 19);
          p  = shr_s(p + v1 + v2, 8) + (p7 << 4);
          r.press_q = p[31:0];
        end
      end
      // humidity needs a nonzero fine term
      if (mask[2] && !skip_h) begin
        if (t_fine == 32'd0) begin
          r.status = ST_NOTEMP;
        end else begin
          tf = sext({32'd0, t_fine}, 32);
          h1 = cal[CFG_HUM] & 64'hFF;
          h2 = sext(cal[CFG_HUM] >> 8, 16);
          h3 = (cal[CFG_HUM] >> 24) & 64'hFF;
          h4 = sext(cal[CFG_HUM] >> 32, 12);
          h5 = sext(cal[CFG_HUM] >> 44, 12);
          h6 = sext(cal[CFG_HUM] >> 56, 8);
          v = tf - 64'd76800;
          a = shr_s((adc_h << 14) - (h4 << 20) - h5 * v + 64'd16384, 15);
          b = shr_s(v * h6, 10) * (shr_s(v * h3, 11) + 64'd32768);
          b = shr_s(b, 10) + 64'd2097152;
          b = shr_s(b * h2 + 64'd8192, 14);
          v = a * b;
          c = shr_s(v, 15);
          v = v - shr_s(shr_s(c * c, 7) * h1, 4);
          if ($signed(v) < 0) v = 64'd0;
          if ($signed(v) > 64'sd419430400) v = 64'd419430400;
          r.hum_q = v[28:12];
        end
      end
      pending.push_back(r);
    endfunction

    // Compare one output item against the oldest expectation
    function void check_result(logic [63:0] tdata, logic [1:0] tuser);
      comp_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result tdata=%h status=%0d", $time, tdata, tuser);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (tdata[14:0] !== e.temp_centi) begin
        $display("%0t: temperature expected %h actual %h", $time, e.temp_centi, tdata[14:0]);
        errors++;
      end
      if (tdata[46:15] !== e.press_q) begin
        $display("%0t: pressure expected %h actual %h", $time, e.press_q, tdata[46:15]);
        errors++;
      end
      if (tdata[63:47] !== e.hum_q) begin
        $display("%0t: humidity expected %h actual %h", $time, e.hum_q, tdata[63:47]);
        errors++;
      end
      if (tuser !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, tuser);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [55:0]          s_tdata = '0;  // raw_pressure, raw_temperature, raw_humidity
  logic [2:0]           s_tuser = '0;  // select_mask
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [63:0]          m_tdata;       // temperature_centi, pressure_q24_8, humidity_q7_10
  logic [1:0]           m_tuser;       // status
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  comp_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_count = 0;

  environmental_sensor_compensation_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Receiver: switch among four stall patterns; check results
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    stall_count <= stall_count + 1;
    if (stall_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 0);
      2: m_tready <= (stall_count % 4 == 0);
      default: m_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Watchdog: end the run after a long stretch with no handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_cfg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every expected result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_cal(logic [63:0] ct, logic [63:0] ca, logic [63:0] cb,
                          logic [63:0] cc, logic [63:0] ch);
    drain();
    write_reg(CFG_TEMP, ct);
    write_reg(CFG_PRESS_A, ca);
    write_reg(CFG_PRESS_B, cb);
    write_reg(CFG_PRESS_C, cc);
    write_reg(CFG_HUM, ch);
  endtask

  // Send one item; bursts of random length separated by random gaps
  task automatic send_item(logic [2:0] mask, logic [19:0] rp, logic [19:0] rt,
                           logic [15:0] rh);
    int gap;
    if (burst_left == 0) begin
      gap = int'(($urandom_range(0, 2) == 0) ? $urandom_range(1, 260) : $urandom_range(0, 6));
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mask;
    s_tdata  <= {rh, rt, rp};
    do @(posedge clk); while (!s_tready);
    sb.note_input(mask, rp, rt, rh);
    burst_left--;
  endtask

  task automatic send_random(int count);
    logic [2:0] mask;
    for (int i = 0; i < count; i++) begin
      mask = ($urandom_range(0, 1) == 0) ? 3'd7 : 3'($urandom_range(0, 7));
      send_item(mask, 20'($urandom), 20'($urandom), 16'($urandom));
    end
  endtask

  function automatic logic [63:0] rand64();
    return {32'($urandom), 32'($urandom)};
  endfunction

  // Typical calibration set of a real part
  localparam logic [63:0] TYP_T  = 64'({16'(-1000), 16'd26435, 16'd27504});
  localparam logic [63:0] TYP_PA = 64'({16'd3024, 16'(-10685), 16'd36477});
  localparam logic [63:0] TYP_PB = 64'({16'(-7), 16'd140, 16'd2855});
  localparam logic [63:0] TYP_PC = 64'({16'd6000, 16'(-14600), 16'd15500});
  localparam logic [63:0] TYP_H  = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero calibration: humidity lacks temperature, zero divisor, empty mask
    send_item(3'b100, 20'd500000, 20'd500000, 16'd30000);
    send_item(3'b000, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_item(3'b001, 20'd400000, 20'd0, 16'd0);
    send_item(3'b101, 20'd400000, 20'd0, 16'd0);
    send_item(3'b111, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_item(3'b110, 20'd0, 20'd0, 16'd0);

    // Typical calibration: extremes, every selection, kept fine term
    load_cal(TYP_T, TYP_PA, TYP_PB, TYP_PC, TYP_H);
    send_item(3'b100, 20'd0, 20'd0, 16'd20000);
    send_item(3'b010, 20'd0, 20'd519888, 16'd0);
    send_item(3'b101, 20'd415148, 20'd0, 16'd25000);
    send_item(3'b001, 20'd0, 20'd0, 16'd0);
    send_item(3'b001, 20'hFFFFF, 20'd0, 16'd0);
    send_item(3'b100, 20'd0, 20'd0, 16'hFFFF);
    send_item(3'b100, 20'd0, 20'd0, 16'd0);
    send_item(3'b010, 20'd0, 20'd0, 16'd0);
    send_item(3'b010, 20'd0, 20'hFFFFF, 16'd0);
    send_item(3'b011, 20'd300000, 20'd600000, 16'd0);
    send_item(3'b110, 20'd0, 20'd450000, 16'd40000);
    send_item(3'b111, 20'd415148, 20'd519888, 16'd28000);
    send_item(3'b000, 20'd1, 20'd1, 16'd1);
    send_random(300);

    // All-ones calibration
    load_cal('1, '1, '1, '1, '1);
    send_random(100);

    // Most negative and most positive signed fields
    load_cal(64'({16'h8000, 16'h8000, 16'hFFFF}), 64'({16'h7FFF, 16'h7FFF, 16'hFFFF}),
             64'({16'h8000, 16'h7FFF, 16'h8000}), 64'({16'h7FFF, 16'h8000, 16'h7FFF}),
             {8'h80, 12'h7FF, 12'h800, 8'hFF, 16'h7FFF, 8'hFF});
    send_random(100);

    // Random calibrations, refreshed often
    for (int k = 0; k < 5; k++) begin
      load_cal(rand64(), rand64(), rand64(), rand64(), rand64());
      send_random(50);
    end

    // Typical calibration again with random readings
    load_cal(TYP_T, TYP_PA, TYP_PB, TYP_PC, TYP_H);
    send_random(100);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
